// ----- sv/aral_pkg.sv -----
// Shared types and codes of the aligned range allocator.
package aral_pkg;

  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_NO_GAP  = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FLUSH,
    S_INSERT,
    S_DONE
  } fsm_t;

  localparam logic [2:0] REG_REGION_START = 3'd0;
  localparam logic [2:0] REG_REGION_END   = 3'd4;

  typedef struct packed {
    logic [31:0] window_first;
    logic [31:0] window_last;
    logic [31:0] length;
    logic [4:0]  align_log2;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] base_addr;
    logic [3:0]  slot;
    logic [4:0]  ranges_used;
  } resp_t;

  typedef struct packed {
    logic rotate;
    logic insert;
  } cell_ctrl_t;

endpackage

// ----- sv/aral_cell.sv -----
// One table cell: holds a range, rotates around the ring or shifts on insert.
module aral_cell #(
  parameter int ADDR_W = 32,
  parameter int SW     = 4,
  parameter int IDX    = 0
) (
  input  logic                clk,
  input  aral_pkg::cell_ctrl_t ctrl,
  input  logic [SW-1:0]       slot,
  input  logic [ADDR_W-1:0]   prev_first,
  input  logic [ADDR_W-1:0]   prev_last,
  input  logic [ADDR_W-1:0]   next_first,
  input  logic [ADDR_W-1:0]   next_last,
  input  logic [ADDR_W-1:0]   new_first,
  input  logic [ADDR_W-1:0]   new_last,
  output logic [ADDR_W-1:0]   first_addr,
  output logic [ADDR_W-1:0]   last_addr
);

  localparam logic [SW-1:0] IDX_V = SW'(IDX);

  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      // advance toward cell 0 so the next range reaches the evaluator
      first_addr <= next_first;
      last_addr  <= next_last;
    end else if (ctrl.insert && IDX_V > slot) begin
      first_addr <= prev_first;
      last_addr  <= prev_last;
    end else if (ctrl.insert && IDX_V == slot) begin
      first_addr <= new_first;
      last_addr  <= new_last;
    end
  end

endmodule

// ----- sv/aral_gap.sv -----
// Gap evaluation pipeline: bound the gap, align its base, check the length.
module aral_gap #(
  parameter int ADDR_W = 32,
  parameter int SW     = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              first_gap,
  input  logic              has_bound,
  input  logic [ADDR_W-1:0] bound_first,
  input  logic [ADDR_W-1:0] prev_last,
  input  logic [ADDR_W-1:0] lo,
  input  logic [ADDR_W-1:0] hi,
  input  logic [SW-1:0]     tag,
  input  logic [4:0]        align_log2,
  input  logic [((ADDR_W > 32) ? ADDR_W : 32)-1:0] len_m1,
  output logic              hit,
  output logic [ADDR_W-1:0] base,
  output logic [SW-1:0]     hit_tag
);

  localparam int XW = (ADDR_W > 32) ? ADDR_W : 32;

  // stage A: gap bounds
  logic              a_valid;
  logic              a_ok;
  logic [ADDR_W-1:0] a_lo;
  logic [ADDR_W-1:0] a_hi;
  logic [SW-1:0]     a_tag;
  logic              ok_c;
  logic [ADDR_W-1:0] glo_c;
  logic [ADDR_W-1:0] ghi_c;
  logic [ADDR_W-1:0] after_c;
  logic [ADDR_W-1:0] bnd_m1;

  always_comb begin
    ok_c    = 1'b1;
    ghi_c   = hi;
    after_c = prev_last + ADDR_W'(1);
    bnd_m1  = bound_first - ADDR_W'(1);
    glo_c   = lo;
    if (!first_gap) begin
      if (&prev_last) begin
        ok_c = 1'b0;
      end
      if (after_c > lo) begin
        glo_c = after_c;
      end
    end
    if (has_bound) begin
      if (bound_first == '0) begin
        ok_c = 1'b0;
      end else if (bnd_m1 < ghi_c) begin
        ghi_c = bnd_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= load;
    end
    a_ok  <= ok_c;
    a_lo  <= glo_c;
    a_hi  <= ghi_c;
    a_tag <= tag;
  end

  // stage B: round the low end up to the alignment
  logic              b_valid;
  logic              b_ok;
  logic [ADDR_W-1:0] b_base;
  logic [ADDR_W-1:0] b_hi;
  logic [SW-1:0]     b_tag;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W:0]   rounded;

  assign mask    = ~({ADDR_W{1'b1}} << align_log2);
  assign rounded = {1'b0, a_lo | mask} + (ADDR_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    if ((a_lo & mask) == '0) begin
      b_base <= a_lo;
      b_ok   <= a_ok && (a_lo <= a_hi);
    end else begin
      b_base <= rounded[ADDR_W-1:0];
      b_ok   <= a_ok && (a_lo <= a_hi) && !rounded[ADDR_W];
    end
    b_hi  <= a_hi;
    b_tag <= a_tag;
  end

  // stage C: base inside the gap and room for the length
  logic [ADDR_W-1:0] room;

  assign room    = b_hi - b_base;
  assign hit     = b_valid && b_ok && (b_base <= b_hi) && (len_m1 <= XW'(room));
  assign base    = b_base;
  assign hit_tag = b_tag;

endmodule

// ----- sv/aligned_range_allocator.sv -----
// Aligned range allocator: first-fit placement into a sorted table of ranges.
//
// Requests arrive on req_valid/req_stall/req_data; a transaction is taken when
// valid is high and stall is low. Each request gets exactly one response on
// resp_valid/resp_stall/resp_data with a status, the granted base, the table
// slot and the number of ranges in use afterwards.
// One request is in work at a time. A request that is rejected up front (bad,
// table full, empty clipped window) goes from the check straight to the
// response. Any other request is searched: the table sits in a ring of
// MAX_RANGES cells that rotates once past a three-stage gap evaluator, then
// the new range is shifted into its sorted slot.
// The next request is taken in the cycle after the response is loaded.
// The region bounds are written through the APB port (region_start at 0x0,
// region_end at 0x4) and must only change while the block is idle.
// Reset empties the table and sets the region to the whole address space.
// A stalled response holds in the output register; the block finishes the
// next request but keeps it back until the output register frees up.
module aligned_range_allocator #(
  parameter int MAX_RANGES = 16,
  parameter int ADDR_W     = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  aral_pkg::req_t      req_data,
  output logic                resp_valid,
  input  logic                resp_stall,
  output aral_pkg::resp_t     resp_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int XW = (ADDR_W > 32) ? ADDR_W : 32;
  localparam int SW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);

  // configuration
  logic [ADDR_W-1:0] region_start;
  logic [ADDR_W-1:0] region_end;
  logic [XW-1:0]     wdata_x;

  assign pready  = 1'b1;
  assign wdata_x = XW'(pwdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_end   <= '1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr == aral_pkg::REG_REGION_START) begin
        region_start <= wdata_x[ADDR_W-1:0];
      end else if (paddr == aral_pkg::REG_REGION_END) begin
        region_end <= wdata_x[ADDR_W-1:0];
      end
    end
  end

  logic [XW-1:0] rs_x;
  logic [XW-1:0] re_x;
  assign rs_x = XW'(region_start);
  assign re_x = XW'(region_end);

  always_comb begin
    prdata = '0;
    if (paddr == aral_pkg::REG_REGION_START) begin
      prdata = rs_x[31:0];
    end else if (paddr == aral_pkg::REG_REGION_END) begin
      prdata = re_x[31:0];
    end
  end

  // request registers
  aral_pkg::fsm_t    state;
  aral_pkg::fsm_t    state_next;
  logic              accept;
  logic              bad;
  logic              empty;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;
  logic [XW-1:0]     len_m1;
  logic [4:0]        align_k;
  logic [XW-1:0]     wf_x;
  logic [XW-1:0]     wl_x;
  logic [XW-1:0]     lo_x;
  logic [XW-1:0]     hi_x;

  assign req_stall = (state != aral_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign wf_x      = XW'(req_data.window_first);
  assign wl_x      = XW'(req_data.window_last);
  assign lo_x      = (wf_x > rs_x) ? wf_x : rs_x;
  assign hi_x      = (wl_x < re_x) ? wl_x : re_x;

  always_ff @(posedge clk) begin
    if (accept) begin
      bad     <= (req_data.length == '0) || (req_data.window_first > req_data.window_last);
      empty   <= lo_x > hi_x;
      lo      <= lo_x[ADDR_W-1:0];
      hi      <= hi_x[ADDR_W-1:0];
      len_m1  <= XW'(req_data.length - 32'd1);
      align_k <= req_data.align_log2;
    end
  end

  // ring of table cells
  logic [ADDR_W-1:0]    cell_first [MAX_RANGES];
  logic [ADDR_W-1:0]    cell_last  [MAX_RANGES];
  aral_pkg::cell_ctrl_t cell_ctrl;
  logic [SW-1:0]        found_slot;
  logic [ADDR_W-1:0]    found_base;
  logic [ADDR_W-1:0]    new_last;

  assign new_last = found_base + len_m1[ADDR_W-1:0];

  for (genvar j = 0; j < MAX_RANGES; j++) begin : g_cell
    localparam int P = (j + MAX_RANGES - 1) % MAX_RANGES;
    localparam int N = (j + 1) % MAX_RANGES;
    aral_cell #(
      .ADDR_W (ADDR_W),
      .SW     (SW),
      .IDX    (j)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .slot       (found_slot),
      .prev_first (cell_first[P]),
      .prev_last  (cell_last[P]),
      .next_first (cell_first[N]),
      .next_last  (cell_last[N]),
      .new_first  (found_base),
      .new_last   (new_last),
      .first_addr (cell_first[j]),
      .last_addr  (cell_last[j])
    );
  end

  // gap evaluator
  logic          gap_load;
  logic          gap_first;
  logic          gap_has_bound;
  logic [ADDR_W-1:0] gap_bound;
  logic [SW-1:0] gap_tag;
  logic          hit;
  logic [ADDR_W-1:0] hit_base;
  logic [SW-1:0] hit_tag;

  logic [CW-1:0] count;
  logic [SW-1:0] step;
  logic [CW-1:0] step_x;
  logic [CW-1:0] step_p1;

  assign step_x  = CW'(step);
  assign step_p1 = step_x + CW'(1);

  always_comb begin
    if (state == aral_pkg::S_CHECK) begin
      gap_load      = !bad && (count < CW'(MAX_RANGES)) && !empty;
      gap_first     = 1'b1;
      gap_has_bound = (count != '0);
      gap_bound     = cell_first[0];
      gap_tag       = '0;
    end else begin
      gap_load      = (state == aral_pkg::S_SCAN) && (step_x < count);
      gap_first     = 1'b0;
      gap_has_bound = (step_p1 < count);
      gap_bound     = cell_first[1 % MAX_RANGES];
      gap_tag       = step_p1[SW-1:0];
    end
  end

  aral_gap #(
    .ADDR_W (ADDR_W),
    .SW     (SW)
  ) u_gap (
    .clk         (clk),
    .rst         (rst),
    .load        (gap_load),
    .first_gap   (gap_first),
    .has_bound   (gap_has_bound),
    .bound_first (gap_bound),
    .prev_last   (cell_last[0]),
    .lo          (lo),
    .hi          (hi),
    .tag         (gap_tag),
    .align_log2  (align_k),
    .len_m1      (len_m1),
    .hit         (hit),
    .base        (hit_base),
    .hit_tag     (hit_tag)
  );

  // sequencer
  logic              found;
  logic              flush_cnt;
  aral_pkg::status_t res_status;
  logic [ADDR_W-1:0] res_base;
  logic [SW-1:0]     res_slot;
  logic              out_free;

  assign out_free = !resp_valid || !resp_stall;

  always_comb begin
    state_next       = state;
    cell_ctrl.rotate = 1'b0;
    cell_ctrl.insert = 1'b0;
    case (state)
      aral_pkg::S_IDLE: begin
        if (accept) begin
          state_next = aral_pkg::S_CHECK;
        end
      end
      aral_pkg::S_CHECK: begin
        if (gap_load) begin
          state_next = aral_pkg::S_SCAN;
        end else begin
          state_next = aral_pkg::S_DONE;
        end
      end
      aral_pkg::S_SCAN: begin
        cell_ctrl.rotate = 1'b1;
        if (step == SW'(MAX_RANGES - 1)) begin
          state_next = aral_pkg::S_FLUSH;
        end
      end
      aral_pkg::S_FLUSH: begin
        if (flush_cnt) begin
          state_next = aral_pkg::S_INSERT;
        end
      end
      aral_pkg::S_INSERT: begin
        cell_ctrl.insert = found;
        state_next       = aral_pkg::S_DONE;
      end
      aral_pkg::S_DONE: begin
        if (out_free) begin
          state_next = aral_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = aral_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aral_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cell_ctrl.insert) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      aral_pkg::S_CHECK: begin
        step      <= '0;
        flush_cnt <= 1'b0;
        found     <= 1'b0;
        res_base  <= '0;
        res_slot  <= '0;
        if (bad) begin
          res_status <= aral_pkg::ST_BAD;
        end else if (count >= CW'(MAX_RANGES)) begin
          res_status <= aral_pkg::ST_FULL;
        end else begin
          res_status <= aral_pkg::ST_NO_GAP;
        end
      end
      aral_pkg::S_SCAN: begin
        step <= step + SW'(1);
      end
      aral_pkg::S_FLUSH: begin
        flush_cnt <= 1'b1;
      end
      aral_pkg::S_INSERT: begin
        if (found) begin
          res_status <= aral_pkg::ST_GRANTED;
          res_base   <= found_base;
          res_slot   <= found_slot;
        end
      end
      default: begin
      end
    endcase
    // keep the lowest gap that fits
    if (hit && !found && (state == aral_pkg::S_SCAN || state == aral_pkg::S_FLUSH)) begin
      found      <= 1'b1;
      found_base <= hit_base;
      found_slot <= hit_tag;
    end
  end

  // output register
  logic [XW-1:0] base_x;
  logic [31:0]   slot_x;
  logic [31:0]   count_x;

  assign base_x  = XW'(res_base);
  assign slot_x  = 32'(res_slot);
  assign count_x = 32'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (state == aral_pkg::S_DONE && out_free) begin
      resp_valid <= 1'b1;
    end else if (!resp_stall) begin
      resp_valid <= 1'b0;
    end
    if (state == aral_pkg::S_DONE && out_free) begin
      resp_data.status      <= res_status;
      resp_data.base_addr   <= base_x[31:0];
      resp_data.slot        <= slot_x[3:0];
      resp_data.ranges_used <= count_x[4:0];
    end
  end

endmodule
